### design/tkdrl_pkg.sv
// Shared types and constants for the three-key debouncer with repeat and long press.
package tkdrl_pkg;

    localparam int unsigned NUM_KEYS = 3;
    localparam int unsigned NUM_NAV  = 2;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd30;
    localparam logic [CFG_W-1:0] REPEAT_DLY_RST  = 16'd450;
    localparam logic [CFG_W-1:0] REPEAT_INT_RST  = 16'd140;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd600;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_OK   = 3'd1,
        EV_BACK = 3'd2,
        EV_UP   = 3'd3,
        EV_DOWN = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_REPEAT_DLY = 2'd1,
        CFG_REPEAT_INT = 2'd2,
        CFG_LONG_PRESS = 2'd3
    } t_cfg_idx;

endpackage

### design/three_key_debounce_repeat_longpress.sv
// Top level: OK/UP/DOWN key debouncer with auto-repeat and long-press detection.
//
// One poll (timestamp plus raw OK, UP and DOWN levels) is accepted per clock cycle
// while the result side is not stalled. Each poll yields exactly one event byte. A
// poll lands in an input register, and a single pass of subtract-and-compare logic
// against the per-key timing state updates that state and loads the result register.
// Throughput is one poll per cycle unless the result side stalls. Back-pressure on
// the result side holds at most one further poll in the input register. Register
// writes on the configuration channel are always taken.
module three_key_debounce_repeat_longpress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // now_ms[31:0], ok_pressed, up_pressed, down_pressed
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // event_code[2:0], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned TW = tkdrl_pkg::TIME_W;
    localparam int unsigned CW = tkdrl_pkg::CFG_W;

    logic [CW-1:0] r_debounce;
    logic [CW-1:0] r_repeat_dly;
    logic [CW-1:0] r_repeat_int;
    logic [CW-1:0] r_long_press;

    logic          r_in_valid;
    logic [TW-1:0] r_in_now;
    logic [2:0]    r_in_raw;

    logic          r_out_valid;
    logic [2:0]    r_out_code;

    logic [2:0]    r_stable;
    logic [2:0]    r_last_raw;
    logic [TW-1:0] r_change [3];
    logic [TW-1:0] r_press  [3];
    logic [TW-1:0] r_repeat [2];
    logic          r_long_fired;

    logic [2:0]    n_stable;
    logic [2:0]    n_last_raw;
    logic [TW-1:0] n_change [3];
    logic [TW-1:0] n_press  [3];
    logic [TW-1:0] n_repeat [2];
    logic          n_long_fired;
    tkdrl_pkg::t_event n_event;

    logic          fire;
    logic [TW-1:0] eff_change [3];
    logic [2:0]    accept;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_code};
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= tkdrl_pkg::DEBOUNCE_RST;
            r_repeat_dly <= tkdrl_pkg::REPEAT_DLY_RST;
            r_repeat_int <= tkdrl_pkg::REPEAT_INT_RST;
            r_long_press <= tkdrl_pkg::LONG_PRESS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tkdrl_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                tkdrl_pkg::CFG_REPEAT_DLY: r_repeat_dly <= i_cfg_data;
                tkdrl_pkg::CFG_REPEAT_INT: r_repeat_int <= i_cfg_data;
                tkdrl_pkg::CFG_LONG_PRESS: r_long_press <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_now <= i_s_axis_tdata[31:0];
            r_in_raw <= i_s_axis_tdata[34:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_code <= n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable     <= '0;
            r_last_raw   <= '0;
            r_long_fired <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_change[k] <= '0;
                r_press[k]  <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                r_repeat[k] <= '0;
            end
        end else if (fire) begin
            r_stable     <= n_stable;
            r_last_raw   <= n_last_raw;
            r_long_fired <= n_long_fired;
            r_change     <= n_change;
            r_press      <= n_press;
            r_repeat     <= n_repeat;
        end
    end

    // debounce test for every key, independent of evaluation order
    always_comb begin
        logic [TW-1:0] held;
        for (int k = 0; k < 3; k++) begin
            eff_change[k] = (r_in_raw[k] != r_last_raw[k]) ? r_in_now : r_change[k];
            held          = r_in_now - eff_change[k];
            accept[k]     = (held >= {{(TW-CW){1'b0}}, r_debounce})
                            && (r_in_raw[k] != r_stable[k]);
        end
    end

    always_comb begin
        logic [TW-1:0] hold_ok;
        logic [TW-1:0] hold_nav;
        logic [TW-1:0] since_rep;
        n_stable     = r_stable;
        n_last_raw   = r_last_raw;
        n_change     = r_change;
        n_press      = r_press;
        n_repeat     = r_repeat;
        n_long_fired = r_long_fired;
        n_event      = tkdrl_pkg::EV_NONE;

        // OK key: report on release, or BACK once held long enough
        n_last_raw[0] = r_in_raw[0];
        n_change[0]   = eff_change[0];
        if (accept[0]) begin
            n_stable[0] = r_in_raw[0];
            if (r_in_raw[0]) begin
                n_press[0]   = r_in_now;
                n_long_fired = 1'b0;
            end else if (!r_long_fired) begin
                n_event = tkdrl_pkg::EV_OK;
            end
        end
        hold_ok = r_in_now - n_press[0];
        if (n_event == tkdrl_pkg::EV_NONE && n_stable[0] && r_in_raw[0] && !n_long_fired
            && hold_ok >= {{(TW-CW){1'b0}}, r_long_press}) begin
            n_long_fired = 1'b1;
            n_event      = tkdrl_pkg::EV_BACK;
        end

        // UP then DOWN: press edge, then auto-repeat while held
        for (int k = 1; k < 3; k++) begin
            hold_nav  = r_in_now - r_press[k];
            since_rep = r_in_now - r_repeat[k-1];
            if (n_event == tkdrl_pkg::EV_NONE) begin
                n_last_raw[k] = r_in_raw[k];
                n_change[k]   = eff_change[k];
                if (accept[k]) begin
                    n_stable[k] = r_in_raw[k];
                end
                if (accept[k] && r_in_raw[k]) begin
                    n_press[k]    = r_in_now;
                    n_repeat[k-1] = r_in_now;
                    n_event = (k == 1) ? tkdrl_pkg::EV_UP : tkdrl_pkg::EV_DOWN;
                end else if (n_stable[k] && r_in_raw[k]
                             && hold_nav >= {{(TW-CW){1'b0}}, r_repeat_dly}
                             && since_rep >= {{(TW-CW){1'b0}}, r_repeat_int}) begin
                    n_repeat[k-1] = r_in_now;
                    n_event = (k == 1) ? tkdrl_pkg::EV_UP : tkdrl_pkg::EV_DOWN;
                end
            end
        end
    end

endmodule

### bench/key_event_checker.sv
// Checker for the three-key debouncer: predicts each poll's key event and compares results.
module key_event_checker
    import tkdrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_poll_valid,
    input  logic              i_poll_ready,
    input  logic [IN_W-1:0]   i_poll_data,
    input  logic              i_event_valid,
    input  logic              i_event_ready,
    input  logic [OUT_W-1:0]  i_event_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_key_events
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_OK   = 0;
    localparam int KEY_UP   = 1;
    localparam int KEY_DOWN = 2;

    logic              stable     [NUM_KEYS];
    logic              raw_seen   [NUM_KEYS];
    logic [TIME_W-1:0] change_at  [NUM_KEYS];
    logic [TIME_W-1:0] press_at   [NUM_KEYS];
    logic [TIME_W-1:0] repeat_at  [NUM_NAV];
    logic              back_sent;

    logic [CFG_W-1:0]  settle_time_ms;
    logic [CFG_W-1:0]  repeat_delay_ms;
    logic [CFG_W-1:0]  repeat_gap_ms;
    logic [CFG_W-1:0]  long_press_ms;

    t_event            expected_events [$];
    int                fails;
    int                checked;
    int                key_events;

    function automatic logic settle_key(int k, logic raw, logic [TIME_W-1:0] now);
        if (raw != raw_seen[k]) begin
            raw_seen[k]  = raw;
            change_at[k] = now;
        end
        if ((now - change_at[k]) >= settle_time_ms && raw != stable[k]) begin
            stable[k] = raw;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_event ok_event(logic raw, logic [TIME_W-1:0] now);
        if (settle_key(KEY_OK, raw, now)) begin
            if (raw) begin
                press_at[KEY_OK] = now;
                back_sent        = 1'b0;
            end else if (!back_sent) begin
                return EV_OK;
            end
        end
        if (stable[KEY_OK] && raw && !back_sent &&
            (now - press_at[KEY_OK]) >= long_press_ms) begin
            back_sent = 1'b1;
            return EV_BACK;
        end
        return EV_NONE;
    endfunction

    function automatic t_event nav_event(int k, logic raw, logic [TIME_W-1:0] now,
                                         t_event code);
        int r = k - 1;
        if (settle_key(k, raw, now) && raw) begin
            press_at[k]  = now;
            repeat_at[r] = now;
            return code;
        end
        if (stable[k] && raw &&
            (now - press_at[k]) >= repeat_delay_ms &&
            (now - repeat_at[r]) >= repeat_gap_ms) begin
            repeat_at[r] = now;
            return code;
        end
        return EV_NONE;
    endfunction

    function automatic t_event poll_event(logic [IN_W-1:0] poll);
        t_event ev;
        ev = ok_event(poll[32], poll[31:0]);
        if (ev == EV_NONE) ev = nav_event(KEY_UP, poll[33], poll[31:0], EV_UP);
        if (ev == EV_NONE) ev = nav_event(KEY_DOWN, poll[34], poll[31:0], EV_DOWN);
        return ev;
    endfunction

    always @(posedge i_clk) begin
        t_event want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                stable[k]    = 1'b0;
                raw_seen[k]  = 1'b0;
                change_at[k] = '0;
                press_at[k]  = '0;
            end
            for (int r = 0; r < NUM_NAV; r++) repeat_at[r] = '0;
            back_sent       = 1'b0;
            settle_time_ms  = DEBOUNCE_RST;
            repeat_delay_ms = REPEAT_DLY_RST;
            repeat_gap_ms   = REPEAT_INT_RST;
            long_press_ms   = LONG_PRESS_RST;
            expected_events.delete();
            fails      = 0;
            checked    = 0;
            key_events = 0;
        end else begin
            if (i_event_valid && i_event_ready) begin
                if (expected_events.size() == 0) begin
                    $error("event_code: expected none pending, actual %0d",
                           i_event_data[2:0]);
                    fails++;
                end else begin
                    want = expected_events.pop_front();
                    checked++;
                    if (want != EV_NONE) key_events++;
                    if (i_event_data[2:0] !== want) begin
                        $error("event_code: expected %0d, actual %0d",
                               want, i_event_data[2:0]);
                        fails++;
                    end
                    if (i_event_data[OUT_W-1:3] !== '0) begin
                        $error("tdata zero fill: expected 0, actual 0x%0h",
                               i_event_data[OUT_W-1:3]);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DEBOUNCE:   settle_time_ms  = i_cfg_data;
                    CFG_REPEAT_DLY: repeat_delay_ms = i_cfg_data;
                    CFG_REPEAT_INT: repeat_gap_ms   = i_cfg_data;
                    CFG_LONG_PRESS: long_press_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_poll_valid && i_poll_ready) expected_events.push_back(poll_event(i_poll_data));
        end
        o_fail_count <= fails;
        o_pending    <= expected_events.size();
        o_checked    <= checked;
        o_key_events <= key_events;
    end

endmodule

### bench/three_key_debounce_repeat_longpress_test.sv
// Testbench top: drives polls and timing writes into the key debouncer and gives the verdict.
module three_key_debounce_repeat_longpress_test;
    import tkdrl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STALL_LIMIT = 2000;
    localparam logic [2:0] NO_KEY      = 3'b000;
    localparam logic [2:0] OK_KEY      = 3'b001;
    localparam logic [2:0] UP_KEY      = 3'b010;
    localparam logic [2:0] DN_KEY      = 3'b100;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_cfg_idx         cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0] cfg_data  = '0;

    int               fail_count;
    int               pending;
    int               checked;
    int               key_events;
    int               quiet_cycles  = 0;
    int               settings_used = 0;
    bit               idle_free     = 1'b1;

    three_key_debounce_repeat_longpress i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    key_event_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_poll_valid  (s_tvalid),
        .i_poll_ready  (s_tready),
        .i_poll_data   (s_tdata),
        .i_event_valid (m_tvalid),
        .i_event_ready (m_tready),
        .i_event_data  (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_key_events  (key_events)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= idle_free || ($urandom_range(99) >= 33);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // keys: bit 0 ok, bit 1 up, bit 2 down
    task automatic send_poll(input logic [TIME_W-1:0] stamp, input logic [2:0] keys);
        while (!idle_free && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, keys[2], keys[1], keys[0], stamp};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] db, rd, ri, lp);
        put_reg(CFG_DEBOUNCE, db);
        put_reg(CFG_REPEAT_DLY, rd);
        put_reg(CFG_REPEAT_INT, ri);
        put_reg(CFG_LONG_PRESS, lp);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int polls, input logic [CFG_W-1:0] db, rd, ri, lp,
                             input bit calm, input bit hold_mid);
        int unsigned      span;
        logic [TIME_W-1:0] stamp;
        logic [2:0]       keys;
        drain();
        set_timing(db, rd, ri, lp);
        idle_free = calm;
        span  = db;
        if (rd > span) span = rd;
        if (ri > span) span = ri;
        if (lp > span) span = lp;
        stamp = $urandom;
        keys  = NO_KEY;
        for (int n = 0; n < polls; n++) begin
            if (hold_mid && n == polls / 2) drain();
            if ($urandom_range(99) < 8) begin
                stamp = $urandom;
                keys  = 3'($urandom);
            end else begin
                stamp = stamp + $urandom_range(span / 3 + 2);
                for (int k = 0; k < 3; k++)
                    if ($urandom_range(99) < 10) keys[k] = ~keys[k];
            end
            send_poll(stamp, keys);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        idle_free = 1'b1;
        settings_used = 1;

        send_poll(32'd0, NO_KEY);
        send_poll(32'd100, OK_KEY);
        send_poll(32'd130, OK_KEY);
        send_poll(32'd730, OK_KEY);
        send_poll(32'd800, NO_KEY);
        send_poll(32'd830, NO_KEY);
        send_poll(32'd900, OK_KEY);
        send_poll(32'd930, OK_KEY);
        send_poll(32'd1000, NO_KEY);
        send_poll(32'd1030, NO_KEY);
        send_poll(32'd1100, UP_KEY);
        send_poll(32'd1130, UP_KEY);
        send_poll(32'd1580, UP_KEY);
        send_poll(32'd1720, UP_KEY);
        send_poll(32'd1800, NO_KEY);
        send_poll(32'd2000, OK_KEY | UP_KEY | DN_KEY);
        send_poll(32'd2030, OK_KEY | UP_KEY | DN_KEY);
        send_poll(32'd2031, OK_KEY | UP_KEY | DN_KEY);
        send_poll(32'hFFFF_FFF0, OK_KEY | UP_KEY | DN_KEY);
        send_poll(32'h0000_0010, NO_KEY);
        send_poll(32'h0000_0040, NO_KEY);
        drain();
        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(32'd5, OK_KEY);
        send_poll(32'd5, UP_KEY);
        send_poll(32'd5, UP_KEY | DN_KEY);
        drain();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_poll(32'd1000, DN_KEY);
        send_poll(32'd66535, DN_KEY);

        run_phase(190, DEBOUNCE_RST, REPEAT_DLY_RST, REPEAT_INT_RST, LONG_PRESS_RST,
                  1'b1, 1'b0);
        run_phase(190, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        run_phase(190, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        run_phase(190, 16'd2, 16'd8, 16'd3, 16'd12, 1'b0, 1'b1);
        run_phase(190, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        run_phase(190, 16'($urandom_range(40)), 16'($urandom_range(40)),
                  16'($urandom_range(40)), 16'($urandom_range(40)), 1'b0, 1'b0);
        run_phase(190, 16'($urandom_range(9)), 16'($urandom_range(60)),
                  16'($urandom_range(20)), 16'($urandom_range(60)), 1'b0, 1'b0);
        run_phase(190, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'b0, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d polls over %0d timing settings, zero and full-scale included",
                 checked, settings_used);
        $display("%0d of them raised an ok, back, up or down event", key_events);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
